### src/ths_pkg.sv
// ----------------------------------------------------------------------------
// ths_pkg: shared definitions for the terrain height sampler
// Grid geometry, command and register codes, and the types that pass
// between the vertex store and the interpolation pipeline.
// ----------------------------------------------------------------------------
package ths_pkg;

  // Grid and number formats
  localparam int GRID_VERTS  = 256;
  localparam int COORD_W     = $clog2(GRID_VERTS);
  localparam int HEIGHT_BITS = 16;
  localparam int FRAC_W      = 8;
  localparam int POS_W       = COORD_W + FRAC_W;
  localparam int ONE_Q8      = 1 << FRAC_W;

  // Four banks split by the low bit of column and row
  localparam int NUM_BANKS   = 4;
  localparam int BANK_AW     = 2 * (COORD_W - 1);
  localparam int BANK_DEPTH  = (GRID_VERTS * GRID_VERTS) / NUM_BANKS;

  // Interpolation widths
  localparam int DIFF_W      = HEIGHT_BITS + 1;
  localparam int WGT_W       = FRAC_W + 1;
  localparam int PROD_W      = DIFF_W + WGT_W + 1;
  localparam int ACC_W       = PROD_W + 1;

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration registers
  localparam int   CFG_IDX_W   = 1;
  localparam int   CFG_DATA_W  = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 1'd1;
  localparam logic [CFG_DATA_W-1:0] CELLS_RESET = 8'd255;

  // Store access from the accept stage
  typedef struct packed {
    logic                          wr_en;
    logic                          rd_en;
    logic [COORD_W-1:0]            col;
    logic [COORD_W-1:0]            row;
    logic signed [HEIGHT_BITS-1:0] wdata;
  } store_req_t;

  // Four corner heights of one cell
  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] v00;
    logic signed [HEIGHT_BITS-1:0] v01;
    logic signed [HEIGHT_BITS-1:0] v10;
    logic signed [HEIGHT_BITS-1:0] v11;
  } verts_t;

  // Query side information
  typedef struct packed {
    logic              oor;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
  } qinfo_t;

endpackage

### src/ths_ram.sv
// ----------------------------------------------------------------------------
// ths_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read that holds its
// data while the read enable is low.
// ----------------------------------------------------------------------------
module ths_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ths_store.sv
// ----------------------------------------------------------------------------
// ths_store: banked vertex height store
// Four banks keyed by column and row parity, so the four corners of any
// cell are read in the same cycle; loads write one bank.
// ----------------------------------------------------------------------------
module ths_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ths_pkg::store_req_t req_i,
  output ths_pkg::verts_t     verts_o
);
  import ths_pkg::*;

  logic [HEIGHT_BITS-1:0] rdata [NUM_BANKS];
  logic                   x0_q;
  logic                   z0_q;
  logic [COORD_W-1:0]     col_p1;
  logic [COORD_W-1:0]     row_p1;

  assign col_p1 = COORD_W'(req_i.col + COORD_W'(1));
  assign row_p1 = COORD_W'(req_i.row + COORD_W'(1));

  // One bank per parity pair
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic PX = 1'(b % 2);
    localparam logic PZ = 1'(b / 2);

    logic [COORD_W-1:0] rd_col;
    logic [COORD_W-1:0] rd_row;
    logic               bank_we;
    logic [BANK_AW-1:0] waddr;
    logic [BANK_AW-1:0] raddr;

    // Pick the corner column and row that live in this bank
    assign rd_col  = (req_i.col[0] == PX) ? req_i.col : col_p1;
    assign rd_row  = (req_i.row[0] == PZ) ? req_i.row : row_p1;
    assign raddr   = {rd_row[COORD_W-1:1], rd_col[COORD_W-1:1]};
    assign waddr   = {req_i.row[COORD_W-1:1], req_i.col[COORD_W-1:1]};
    assign bank_we = req_i.wr_en && (req_i.col[0] == PX) && (req_i.row[0] == PZ);

    ths_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i (waddr),
      .wdata_i (req_i.wdata),
      .re_i    (req_i.rd_en),
      .raddr_i (raddr),
      .rdata_o (rdata[b])
    );
  end

  // Track cell parity alongside the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_q <= 1'b0;
      z0_q <= 1'b0;
    end else if (req_i.rd_en) begin
      x0_q <= req_i.col[0];
      z0_q <= req_i.row[0];
    end
  end

  // Map banks back to cell corners
  assign verts_o.v00 = rdata[{z0_q, x0_q}];
  assign verts_o.v10 = rdata[{z0_q, ~x0_q}];
  assign verts_o.v01 = rdata[{~z0_q, x0_q}];
  assign verts_o.v11 = rdata[{~z0_q, ~x0_q}];

endmodule

### src/ths_interp.sv
// ----------------------------------------------------------------------------
// ths_interp: triangle interpolation pipeline
// Three stages: triangle setup, weight multiplies, then sum, floor and
// saturation into the output register.
// ----------------------------------------------------------------------------
module ths_interp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ths_pkg::verts_t                verts_i,
  input  ths_pkg::qinfo_t                info_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [ths_pkg::HEIGHT_BITS-1:0] height_out_o,
  output logic                           out_of_range_o
);
  import ths_pkg::*;

  logic en_c, en_d, en_e;

  // Setup stage registers
  logic                          c_v_q;
  logic                          c_oor_q;
  logic signed [HEIGHT_BITS-1:0] c_base_q;
  logic signed [DIFF_W-1:0]      c_d1_q, c_d2_q;
  logic [WGT_W-1:0]              c_w1_q, c_w2_q;
  logic signed [HEIGHT_BITS-1:0] c_base_d;
  logic signed [DIFF_W-1:0]      c_d1_d, c_d2_d;
  logic [WGT_W-1:0]              c_w1_d, c_w2_d;
  logic [WGT_W-1:0]              frac_sum;
  logic                          lower;

  // Multiply stage registers
  logic                          d_v_q;
  logic                          d_oor_q;
  logic signed [HEIGHT_BITS-1:0] d_base_q;
  logic signed [PROD_W-1:0]      d_p1_q, d_p2_q;

  // Output stage
  logic                          e_v_q;
  logic                          e_oor_q;
  logic signed [HEIGHT_BITS-1:0] e_height_q;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-FRAC_W-1:0] floored;
  logic signed [HEIGHT_BITS-1:0] sat;

  // Per-stage advance, bubbles collapse
  assign en_e       = !e_v_q || !out_stall_i;
  assign en_d       = !d_v_q || en_e;
  assign en_c       = !c_v_q || en_d;
  assign in_stall_o = !en_c;

  // Choose triangle and form differences and weights
  assign frac_sum = {1'b0, info_i.fx} + {1'b0, info_i.fz};
  assign lower    = (frac_sum <= WGT_W'(ONE_Q8));

  always_comb begin
    if (lower) begin
      c_base_d = verts_i.v00;
      c_d1_d   = DIFF_W'(verts_i.v10) - DIFF_W'(verts_i.v00);
      c_d2_d   = DIFF_W'(verts_i.v01) - DIFF_W'(verts_i.v00);
      c_w1_d   = {1'b0, info_i.fx};
      c_w2_d   = {1'b0, info_i.fz};
    end else begin
      c_base_d = verts_i.v11;
      c_d1_d   = DIFF_W'(verts_i.v01) - DIFF_W'(verts_i.v11);
      c_d2_d   = DIFF_W'(verts_i.v10) - DIFF_W'(verts_i.v11);
      c_w1_d   = WGT_W'(ONE_Q8) - {1'b0, info_i.fx};
      c_w2_d   = WGT_W'(ONE_Q8) - {1'b0, info_i.fz};
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      if (en_c) c_v_q <= in_valid_i;
      if (en_d) d_v_q <= c_v_q;
      if (en_e) e_v_q <= d_v_q;
    end
  end

  // Setup stage payload
  always_ff @(posedge clk_i) begin
    if (en_c) begin
      c_oor_q  <= info_i.oor;
      c_base_q <= c_base_d;
      c_d1_q   <= c_d1_d;
      c_d2_q   <= c_d2_d;
      c_w1_q   <= c_w1_d;
      c_w2_q   <= c_w2_d;
    end
  end

  // Weight multiplies
  always_ff @(posedge clk_i) begin
    if (en_d) begin
      d_oor_q  <= c_oor_q;
      d_base_q <= c_base_q;
      d_p1_q   <= PROD_W'(c_d1_q * $signed({1'b0, c_w1_q}));
      d_p2_q   <= PROD_W'(c_d2_q * $signed({1'b0, c_w2_q}));
    end
  end

  // Sum in Q20.8, floor to an integer, saturate to Q16.0
  assign acc     = (ACC_W'(d_base_q) <<< FRAC_W) + ACC_W'(d_p1_q) + ACC_W'(d_p2_q);
  assign floored = acc[ACC_W-1:FRAC_W];

  always_comb begin
    if (floored > (ACC_W-FRAC_W)'(signed'({1'b0, {(HEIGHT_BITS-1){1'b1}}})))
      sat = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
    else if (floored < (ACC_W-FRAC_W)'(signed'({1'b1, {(HEIGHT_BITS-1){1'b0}}})))
      sat = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
    else
      sat = floored[HEIGHT_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      e_oor_q    <= d_oor_q;
      e_height_q <= d_oor_q ? '0 : sat;
    end
  end

  assign out_valid_o    = e_v_q;
  assign height_out_o   = e_height_q;
  assign out_of_range_o = e_oor_q;

`ifndef SYNTHESIS
  // An out-of-range result always carries a zero height
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (height_out_o == '0))
    else $error("out-of-range result with nonzero height");
`endif

endmodule

### src/terrain_height_sample.sv
// A query's result reaches the output register through the accept, read, setup, multiply and output stages.
// Throughput: one item (load or query) per cycle while the result channel does not stall; loads give no result.
// Rate is set by the four-bank vertex store, one read port and one write port per bank.
// Reset: control and valid bits clear, cells_x and cells_z return to 255.
// The vertex store is not cleared; entries hold nothing until loaded.
// ----------------------------------------------------------------------------
// terrain_height_sample: heightfield triangle interpolation
// Accept stage with range check, banked store read, then the interpolation
// pipeline with its output register.
// ----------------------------------------------------------------------------
module terrain_height_sample (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Item channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  command_i,
  input  logic [ths_pkg::COORD_W-1:0]           grid_x_i,
  input  logic [ths_pkg::COORD_W-1:0]           grid_z_i,
  input  logic signed [ths_pkg::HEIGHT_BITS-1:0] height_value_i,
  input  logic [ths_pkg::POS_W-1:0]             query_x_i,
  input  logic [ths_pkg::POS_W-1:0]             query_z_i,
  // Result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [ths_pkg::HEIGHT_BITS-1:0] height_out_o,
  output logic                                  out_of_range_o,
  // Configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ths_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ths_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import ths_pkg::*;

  logic                   en_a, en_b;
  logic                   interp_stall;

  // Configuration registers
  logic [CFG_DATA_W-1:0]  cells_x_q, cells_z_q;

  // Accept stage
  logic                   a_v_q;
  logic                   a_cmd_q;
  logic [COORD_W-1:0]     a_gx_q, a_gz_q;
  logic signed [HEIGHT_BITS-1:0] a_h_q;
  logic [POS_W-1:0]       a_qx_q, a_qz_q;
  logic [COORD_W-1:0]     cell_x, cell_z;
  logic                   a_oor;
  store_req_t             st_req;

  // Read stage
  logic                   b_v_q;
  qinfo_t                 b_info_q;
  verts_t                 verts;

  // Stage advance
  assign en_b       = !b_v_q || !interp_stall;
  assign en_a       = !a_v_q || en_b;
  assign in_stall_o = !en_a;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= CELLS_RESET;
      cells_z_q <= CELLS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CELLS_X: cells_x_q <= cfg_data_i;
        CFG_CELLS_Z: cells_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the transferred item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_a) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_cmd_q <= command_i;
      a_gx_q  <= grid_x_i;
      a_gz_q  <= grid_z_i;
      a_h_q   <= height_value_i;
      a_qx_q  <= query_x_i;
      a_qz_q  <= query_z_i;
    end
  end

  // Cell select and range check
  assign cell_x = a_qx_q[POS_W-1:FRAC_W];
  assign cell_z = a_qz_q[POS_W-1:FRAC_W];
  assign a_oor  = (cell_x >= cells_x_q) || (cell_z >= cells_z_q) ||
                  (cell_x == COORD_W'(GRID_VERTS - 1)) ||
                  (cell_z == COORD_W'(GRID_VERTS - 1));

  // Store access: loads write, queries read the cell corners
  always_comb begin
    st_req.wr_en = a_v_q && (a_cmd_q == CMD_LOAD) && en_b;
    st_req.rd_en = en_b;
    st_req.col   = (a_cmd_q == CMD_LOAD) ? a_gx_q : cell_x;
    st_req.row   = (a_cmd_q == CMD_LOAD) ? a_gz_q : cell_z;
    st_req.wdata = a_h_q;
  end

  ths_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (st_req),
    .verts_o (verts)
  );

  // Read stage: only queries move on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en_b) begin
      b_v_q <= a_v_q && (a_cmd_q == CMD_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_info_q.oor <= a_oor;
      b_info_q.fx  <= a_qx_q[FRAC_W-1:0];
      b_info_q.fz  <= a_qz_q[FRAC_W-1:0];
    end
  end

  ths_interp u_interp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (b_v_q),
    .in_stall_o     (interp_stall),
    .verts_i        (verts),
    .info_i         (b_info_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .height_out_o   (height_out_o),
    .out_of_range_o (out_of_range_o)
  );

`ifndef SYNTHESIS
  // Input stalls only when both front stages hold items
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (a_v_q && b_v_q))
    else $error("input stalled with a free front stage");

  // Store writes come only from a load item leaving the accept stage
  a_write_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_req.wr_en |-> (a_v_q && (a_cmd_q == CMD_LOAD) && st_req.rd_en))
    else $error("store write without a load item");

  // A load never enters the read stage
  a_load_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_v_q && (a_cmd_q == CMD_LOAD) && en_b) |=> !b_v_q)
    else $error("load item reached the read stage");
`endif

endmodule
